FILE: design/assert_macros.svh
// Assertion helpers used by the checker file tcch_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock, off while reset is low.
`define TCCH_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// A signal is checked to be stable ($stable) at the sample following each one in which the condition holds.
`define TCCH_ASSERT_STABLE(label, clk, rstn, cond, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> $stable(sig)) \
        else $error(msg);

`endif

FILE: design/tcch_pkg.sv
package tcch_pkg;

    localparam int CORDIC_STEPS = 16;

    localparam int ANG_W = 25;
    localparam int TRIG_W = 32;
    localparam int HORZ_W = 48;

    localparam logic signed [TRIG_W-1:0] CORDIC_START = 32'sd163008218;
    localparam logic signed [ANG_W-1:0] DEG180_UNITS = 25'sd4608000;
    localparam logic signed [ANG_W-1:0] DEG360_UNITS = 25'sd9216000;

    localparam logic signed [ANG_W-1:0] ATAN_UNITS [0:23] = '{
        25'sd1152000, 25'sd680065, 25'sd359328, 25'sd182400, 25'sd91554, 25'sd45822,
        25'sd22916, 25'sd11459, 25'sd5730, 25'sd2865, 25'sd1432, 25'sd716,
        25'sd358, 25'sd179, 25'sd90, 25'sd45, 25'sd22, 25'sd11,
        25'sd6, 25'sd3, 25'sd1, 25'sd1, 25'sd0, 25'sd0
    };

    typedef struct packed {
        logic signed [15:0] mag_x;
        logic signed [15:0] mag_y;
        logic signed [15:0] mag_z;
    } mag_t;

    typedef struct packed {
        logic signed [TRIG_W-1:0] sin_r;
        logic signed [TRIG_W-1:0] cos_r;
        logic signed [TRIG_W-1:0] sin_p;
        logic signed [TRIG_W-1:0] cos_p;
    } trig_t;

    typedef struct packed {
        logic en;
        logic valid;
    } pipe_ctrl_t;

endpackage

FILE: design/tcch_sincos.sv
module tcch_sincos (
    input  logic                clk,
    input  logic                rst_n,
    input  tcch_pkg::pipe_ctrl_t ctrl_in,
    input  logic signed [15:0]  roll_angle,
    input  logic signed [15:0]  pitch_angle,
    input  tcch_pkg::mag_t      mag_in,
    output logic                valid_out,
    output tcch_pkg::trig_t     trig_out,
    output tcch_pkg::mag_t      mag_out
);

    localparam int N = tcch_pkg::CORDIC_STEPS;
    localparam int TW = tcch_pkg::TRIG_W;
    localparam int AW = tcch_pkg::ANG_W;

    logic                 valid_reg [0:N];
    logic signed [TW-1:0] xr_reg [0:N];
    logic signed [TW-1:0] yr_reg [0:N];
    logic signed [AW-1:0] zr_reg [0:N];
    logic                 nr_reg [0:N];
    logic signed [TW-1:0] xp_reg [0:N];
    logic signed [TW-1:0] yp_reg [0:N];
    logic signed [AW-1:0] zp_reg [0:N];
    logic                 np_reg [0:N];
    tcch_pkg::mag_t       mag_reg [0:N];

    logic                 vout_reg;
    tcch_pkg::trig_t      trig_reg;
    tcch_pkg::mag_t       mout_reg;

    logic signed [AW-1:0] zr_next;
    logic signed [AW-1:0] zp_next;
    logic                 nr_next;
    logic                 np_next;

    function automatic logic [AW:0] prep(input logic signed [15:0] ang);
        logic signed [16:0] a;
        logic               neg;
        a = 17'(ang);
        neg = 1'b0;
        if (a > 17'sd18000)
        begin
            a = a - 17'sd36000;
        end
        if (a < -17'sd18000)
        begin
            a = a + 17'sd36000;
        end
        if (a > 17'sd9000)
        begin
            a = a - 17'sd18000;
            neg = 1'b1;
        end
        else if (a < -17'sd9000)
        begin
            a = a + 17'sd18000;
            neg = 1'b1;
        end
        return {neg, a, 8'b0};
    endfunction

    always_comb
    begin
        {nr_next, zr_next} = prep(roll_angle);
        {np_next, zp_next} = prep(pitch_angle);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (ctrl_in.en)
        begin
            valid_reg[0] <= ctrl_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl_in.en)
        begin
            xr_reg[0]  <= tcch_pkg::CORDIC_START;
            yr_reg[0]  <= '0;
            zr_reg[0]  <= zr_next;
            nr_reg[0]  <= nr_next;
            xp_reg[0]  <= tcch_pkg::CORDIC_START;
            yp_reg[0]  <= '0;
            zp_reg[0]  <= zp_next;
            np_reg[0]  <= np_next;
            mag_reg[0] <= mag_in;
        end
    end

    for (genvar k = 0; k < N; k++)
    begin : g_step
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k+1] <= 1'b0;
            end
            else if (ctrl_in.en)
            begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctrl_in.en)
            begin
                if (zr_reg[k] >= 0)
                begin
                    xr_reg[k+1] <= xr_reg[k] - (yr_reg[k] >>> k);
                    yr_reg[k+1] <= yr_reg[k] + (xr_reg[k] >>> k);
                    zr_reg[k+1] <= zr_reg[k] - tcch_pkg::ATAN_UNITS[k];
                end
                else
                begin
                    xr_reg[k+1] <= xr_reg[k] + (yr_reg[k] >>> k);
                    yr_reg[k+1] <= yr_reg[k] - (xr_reg[k] >>> k);
                    zr_reg[k+1] <= zr_reg[k] + tcch_pkg::ATAN_UNITS[k];
                end
                if (zp_reg[k] >= 0)
                begin
                    xp_reg[k+1] <= xp_reg[k] - (yp_reg[k] >>> k);
                    yp_reg[k+1] <= yp_reg[k] + (xp_reg[k] >>> k);
                    zp_reg[k+1] <= zp_reg[k] - tcch_pkg::ATAN_UNITS[k];
                end
                else
                begin
                    xp_reg[k+1] <= xp_reg[k] + (yp_reg[k] >>> k);
                    yp_reg[k+1] <= yp_reg[k] - (xp_reg[k] >>> k);
                    zp_reg[k+1] <= zp_reg[k] + tcch_pkg::ATAN_UNITS[k];
                end
                nr_reg[k+1]  <= nr_reg[k];
                np_reg[k+1]  <= np_reg[k];
                mag_reg[k+1] <= mag_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vout_reg <= 1'b0;
        end
        else if (ctrl_in.en)
        begin
            vout_reg <= valid_reg[N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl_in.en)
        begin
            trig_reg.sin_r <= nr_reg[N] ? -yr_reg[N] : yr_reg[N];
            trig_reg.cos_r <= nr_reg[N] ? -xr_reg[N] : xr_reg[N];
            trig_reg.sin_p <= np_reg[N] ? -yp_reg[N] : yp_reg[N];
            trig_reg.cos_p <= np_reg[N] ? -xp_reg[N] : xp_reg[N];
            mout_reg       <= mag_reg[N];
        end
    end

    assign valid_out = vout_reg;
    assign trig_out  = trig_reg;
    assign mag_out   = mout_reg;

endmodule

FILE: design/tcch_tilt.sv
module tcch_tilt (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tcch_pkg::pipe_ctrl_t ctrl_in,
    input  tcch_pkg::trig_t      trig_in,
    input  tcch_pkg::mag_t       mag_in,
    output logic                 valid_out,
    output logic signed [tcch_pkg::HORZ_W-1:0] hx,
    output logic signed [tcch_pkg::HORZ_W-1:0] hy
);

    localparam int TW = tcch_pkg::TRIG_W;
    localparam int HW = tcch_pkg::HORZ_W;

    logic [2:0]             valid_reg;
    logic signed [2*TW-1:0] srsp_reg;
    logic signed [2*TW-1:0] crsp_reg;
    tcch_pkg::trig_t        trig_reg;
    tcch_pkg::mag_t         mag_reg;
    logic signed [HW-1:0]   p_xcp_reg;
    logic signed [HW-1:0]   p_ysp_reg;
    logic signed [HW-1:0]   p_zcp_reg;
    logic signed [HW-1:0]   p_ycr_reg;
    logic signed [HW-1:0]   p_zsr_reg;
    logic signed [HW-1:0]   hx_reg;
    logic signed [HW-1:0]   hy_reg;

    logic signed [TW-1:0]   srsp_q;
    logic signed [TW-1:0]   crsp_q;

    assign srsp_q = srsp_reg[TW+27:28];
    assign crsp_q = crsp_reg[TW+27:28];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ctrl_in.en)
        begin
            valid_reg <= {valid_reg[1:0], ctrl_in.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl_in.en)
        begin
            srsp_reg  <= (2*TW)'(trig_in.sin_r) * (2*TW)'(trig_in.sin_p);
            crsp_reg  <= (2*TW)'(trig_in.cos_r) * (2*TW)'(trig_in.sin_p);
            trig_reg  <= trig_in;
            mag_reg   <= mag_in;
            p_xcp_reg <= HW'(mag_reg.mag_x) * HW'(trig_reg.cos_p);
            p_ysp_reg <= HW'(mag_reg.mag_y) * HW'(srsp_q);
            p_zcp_reg <= HW'(mag_reg.mag_z) * HW'(crsp_q);
            p_ycr_reg <= HW'(mag_reg.mag_y) * HW'(trig_reg.cos_r);
            p_zsr_reg <= HW'(mag_reg.mag_z) * HW'(trig_reg.sin_r);
            hx_reg    <= p_xcp_reg - p_ysp_reg + p_zcp_reg;
            hy_reg    <= p_ycr_reg + p_zsr_reg;
        end
    end

    assign valid_out = valid_reg[2];
    assign hx = hx_reg;
    assign hy = hy_reg;

endmodule

FILE: design/tcch_atan.sv
module tcch_atan (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tcch_pkg::pipe_ctrl_t ctrl_in,
    input  logic signed [tcch_pkg::HORZ_W-1:0] hx,
    input  logic signed [tcch_pkg::HORZ_W-1:0] hy,
    output logic                 valid_out,
    output logic                 zero_out,
    output logic signed [tcch_pkg::ANG_W-1:0] angle
);

    localparam int N = tcch_pkg::CORDIC_STEPS;
    localparam int HW = tcch_pkg::HORZ_W;
    localparam int AW = tcch_pkg::ANG_W;

    logic                 valid_reg [0:N];
    logic                 zero_reg [0:N];
    logic signed [HW-1:0] x_reg [0:N];
    logic signed [HW-1:0] y_reg [0:N];
    logic signed [AW-1:0] z_reg [0:N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (ctrl_in.en)
        begin
            valid_reg[0] <= ctrl_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl_in.en)
        begin
            zero_reg[0] <= (hx == '0) && (hy == '0);
            if (hx < 0)
            begin
                x_reg[0] <= -hx;
                y_reg[0] <= -hy;
                z_reg[0] <= (hy >= 0) ? tcch_pkg::DEG180_UNITS : -tcch_pkg::DEG180_UNITS;
            end
            else
            begin
                x_reg[0] <= hx;
                y_reg[0] <= hy;
                z_reg[0] <= '0;
            end
        end
    end

    for (genvar k = 0; k < N; k++)
    begin : g_step
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k+1] <= 1'b0;
            end
            else if (ctrl_in.en)
            begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctrl_in.en)
            begin
                if (y_reg[k] < 0)
                begin
                    x_reg[k+1] <= x_reg[k] - (y_reg[k] >>> k);
                    y_reg[k+1] <= y_reg[k] + (x_reg[k] >>> k);
                    z_reg[k+1] <= z_reg[k] - tcch_pkg::ATAN_UNITS[k];
                end
                else
                begin
                    x_reg[k+1] <= x_reg[k] + (y_reg[k] >>> k);
                    y_reg[k+1] <= y_reg[k] - (x_reg[k] >>> k);
                    z_reg[k+1] <= z_reg[k] + tcch_pkg::ATAN_UNITS[k];
                end
                zero_reg[k+1] <= zero_reg[k];
            end
        end
    end

    assign valid_out = valid_reg[N];
    assign zero_out  = zero_reg[N];
    assign angle     = z_reg[N];

endmodule

FILE: design/tilt_compensated_compass_heading.sv
// Throughput: one word per cycle; the sine/cosine and atan2 CORDIC pipelines advance
// one rotation step per stage, and the whole pipeline holds while the result is not taken.
// Reset: rst_n is asynchronous and active low; it clears all valid bits and sets the
// declination to zero.
module tilt_compensated_compass_heading (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,  // mag_x, mag_y, mag_z, roll_angle, pitch_angle
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata   // heading
);

    localparam int HW = tcch_pkg::HORZ_W;
    localparam int AW = tcch_pkg::ANG_W;

    logic [15:0]          decl_reg;
    logic                 adv;
    tcch_pkg::pipe_ctrl_t ctrl_sc;
    tcch_pkg::pipe_ctrl_t ctrl_tl;
    tcch_pkg::pipe_ctrl_t ctrl_at;
    tcch_pkg::mag_t       mag_in;
    tcch_pkg::mag_t       mag_sc;
    tcch_pkg::trig_t      trig_sc;
    logic                 valid_sc;
    logic                 valid_tl;
    logic                 valid_at;
    logic                 zero_at;
    logic signed [HW-1:0] hx;
    logic signed [HW-1:0] hy;
    logic signed [AW-1:0] angle;

    logic                 f1_valid_reg;
    logic signed [17:0]   f1_h_reg;
    logic                 out_valid_reg;
    logic [15:0]          out_reg;

    logic signed [AW-1:0] z_pos;
    logic signed [AW-1:0] z_rnd;
    logic signed [17:0]   h_next;
    logic signed [17:0]   h_wrap;

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;

    assign mag_in.mag_x = s_tdata[15:0];
    assign mag_in.mag_y = s_tdata[31:16];
    assign mag_in.mag_z = s_tdata[47:32];

    assign ctrl_sc = '{en: adv, valid: s_tvalid};
    assign ctrl_tl = '{en: adv, valid: valid_sc};
    assign ctrl_at = '{en: adv, valid: valid_tl};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decl_reg <= '0;
        end
        else if (cfg_we)
        begin
            decl_reg <= cfg_wdata;
        end
    end

    tcch_sincos u_sincos (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl_in     (ctrl_sc),
        .roll_angle  (s_tdata[63:48]),
        .pitch_angle (s_tdata[79:64]),
        .mag_in      (mag_in),
        .valid_out   (valid_sc),
        .trig_out    (trig_sc),
        .mag_out     (mag_sc)
    );

    tcch_tilt u_tilt (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl_in   (ctrl_tl),
        .trig_in   (trig_sc),
        .mag_in    (mag_sc),
        .valid_out (valid_tl),
        .hx        (hx),
        .hy        (hy)
    );

    tcch_atan u_atan (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl_in   (ctrl_at),
        .hx        (hx),
        .hy        (hy),
        .valid_out (valid_at),
        .zero_out  (zero_at),
        .angle     (angle)
    );

    always_comb
    begin
        if (zero_at)
        begin
            z_pos = '0;
        end
        else if (angle < 0)
        begin
            z_pos = angle + tcch_pkg::DEG360_UNITS;
        end
        else
        begin
            z_pos = angle;
        end
        z_rnd  = z_pos + AW'(128);
        h_next = 18'(z_rnd >>> 8) + 18'($signed(decl_reg));
    end

    always_comb
    begin
        if (f1_h_reg < 0)
        begin
            h_wrap = f1_h_reg + 18'sd36000;
        end
        else if (f1_h_reg >= 18'sd36000)
        begin
            h_wrap = f1_h_reg - 18'sd36000;
        end
        else
        begin
            h_wrap = f1_h_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            f1_valid_reg  <= valid_at;
            out_valid_reg <= f1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f1_h_reg <= h_next;
            out_reg  <= 16'(18'sd36000 - h_wrap);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

endmodule

FILE: design/tcch_checker.sv
`include "assert_macros.svh"

module tcch_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    `TCCH_ASSERT(a_out_hold, clk, rst_n, m_tvalid && !m_tready |=> m_tvalid, "result word dropped")
    `TCCH_ASSERT_STABLE(a_out_stable, clk, rst_n, m_tvalid && !m_tready, m_tdata, "result word changed")
    `TCCH_ASSERT(a_out_range, clk, rst_n, m_tvalid |-> (m_tdata >= 16'd1) && (m_tdata <= 16'd36000), "heading out of range")
    `TCCH_ASSERT(a_ready_empty, clk, rst_n, !m_tvalid |-> s_tready, "input stalled with empty output")
    `TCCH_ASSERT(a_ready_stall, clk, rst_n, m_tvalid && !m_tready |-> !s_tready, "input taken during stall")

endmodule

bind tilt_compensated_compass_heading tcch_checker u_tcch_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
